// ----- design/age_ordered_address_buffer_macros.svh -----
// Assertion macros shared by the checker of the age-ordered address buffer.
// Each macro expands to one labeled concurrent assertion clocked on the rising
// edge and disabled while reset is high.
`ifndef AGE_ORDERED_ADDRESS_BUFFER_MACROS_SVH
`define AGE_ORDERED_ADDRESS_BUFFER_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds at that edge.
`define AOAB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds at the next edge.
`define AOAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/aoab_pkg.sv -----
// Package for the age-ordered address buffer: field widths, stream widths,
// default sizes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aoab_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_SLOTS     = 8;
  localparam int DEF_ROB_DEPTH = 32;

  // Fixed field widths.
  localparam int ADDR_W = 32;
  localparam int TAG_W  = 5;
  localparam int MIDX_W = 4;

  // Stream widths, rounded up to whole bytes.
  localparam int IN_BITS     = 1 + 2 * ADDR_W + TAG_W + MIDX_W + 1 + TAG_W + TAG_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 1 + ADDR_W + TAG_W + MIDX_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // Capture an input beat and start a new scan.
    logic scan;    // Examine the slot under the scan pointer.
    logic commit;  // Update the slots and load the result register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // The scan pointer sits on the last slot.
  } sts_t;

endpackage

`default_nettype wire

// ----- design/age_ordered_address_buffer.sv -----
// Age-ordered address buffer. Each input beat carries one tick: an optional
// dispatched memory operation (address = operand_a + operand_b, wrapping),
// a squash request and the reorder-buffer head. Each tick yields exactly one
// output beat reporting the oldest entry held before the tick (given out and
// freed) and whether all slots were busy. An item passes from acceptance to
// result through capture (forming the address), a scan in which the scan
// unit examines one slot per cycle for the oldest entry and the first free
// slot, and a commit that waits for the result register. The result register
// lets the next beat be accepted while a result still waits on the output.
// Depends on aoab_pkg, aoab_ctrl and aoab_dp.
`timescale 1ns / 1ps
`default_nettype none

module age_ordered_address_buffer #(
  parameter int SLOTS     = aoab_pkg::DEF_SLOTS,
  parameter int ROB_DEPTH = aoab_pkg::DEF_ROB_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: dispatch_valid, operand_a, operand_b, rob_tag,
  // mem_index, squash, squash_tag, rob_head, zero padding.
  input  wire logic [aoab_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // Fields from bit 0: head_valid, head_address, head_rob_tag,
  // head_mem_index, buffer_full, zero padding.
  output logic      [aoab_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  aoab_pkg::cmd_t cmd;
  aoab_pkg::sts_t sts;

  // Sequencer and handshakes.
  aoab_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // Slots, scan unit and result register.
  aoab_dp #(
    .SLOTS     (SLOTS),
    .ROB_DEPTH (ROB_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- design/aoab_ctrl.sv -----
// Controller of the age-ordered address buffer: sequences accept, slot scan
// and commit, and owns both stream handshakes. Uses aoab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aoab_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  input  wire aoab_pkg::sts_t sts,
  output aoab_pkg::cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // The result register can take a new beat when empty or being drained.
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/aoab_dp.sv -----
// Datapath of the age-ordered address buffer: slot storage, the serial
// oldest/free scan, the commit update with squash, and the result register.
// Uses aoab_pkg; driven by aoab_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module aoab_dp #(
  parameter int SLOTS     = aoab_pkg::DEF_SLOTS,
  parameter int ROB_DEPTH = aoab_pkg::DEF_ROB_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire aoab_pkg::cmd_t                   cmd,
  output aoab_pkg::sts_t                        sts,
  input  wire logic [aoab_pkg::IN_TDATA_W-1:0]  in_data,
  output logic      [aoab_pkg::OUT_TDATA_W-1:0] out_data
);

  localparam int ADDR_W    = aoab_pkg::ADDR_W;
  localparam int TAG_W     = aoab_pkg::TAG_W;
  localparam int MIDX_W    = aoab_pkg::MIDX_W;
  localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW        = $clog2(ROB_DEPTH);
  localparam int TAG_RANGE = 1 << TAG_W;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
  localparam logic [AW:0]   DEPTH_V  = (AW + 1)'(ROB_DEPTH);

  // Tag modulo the reorder depth, as a constant table built by counting.
  function automatic logic [TAG_RANGE*AW-1:0] build_mod_table();
    logic [TAG_RANGE*AW-1:0] t;
    int v;
    t = '0;
    v = 0;
    for (int i = 0; i < TAG_RANGE; i++) begin
      t[i*AW +: AW] = AW'(v);
      v = (v + 1 == ROB_DEPTH) ? 0 : v + 1;
    end
    return t;
  endfunction

  localparam logic [TAG_RANGE*AW-1:0] MOD_TABLE = build_mod_table();

  function automatic logic [AW-1:0] tag_mod(input logic [TAG_W-1:0] tag);
    return MOD_TABLE[tag*AW +: AW];
  endfunction

  // Distance of a tag from the reduced head; smaller means older.
  function automatic logic [AW-1:0] age_of(input logic [TAG_W-1:0] tag,
                                          input logic [AW-1:0]    hm);
    logic [AW-1:0] tm;
    logic [AW:0]   d;
    tm = tag_mod(tag);
    if (tm >= hm) begin
      d = {1'b0, tm} - {1'b0, hm};
    end else begin
      d = {1'b0, tm} + DEPTH_V - {1'b0, hm};
    end
    return d[AW-1:0];
  endfunction

  // Slot storage.
  logic [SLOTS-1:0]  slot_valid;
  logic [ADDR_W-1:0] slot_address [SLOTS];
  logic [TAG_W-1:0]  slot_tag     [SLOTS];
  logic [MIDX_W-1:0] slot_qidx    [SLOTS];

  // Captured input beat.
  logic              dv_r;
  logic [ADDR_W-1:0] addr_r;
  logic [TAG_W-1:0]  tag_r;
  logic [MIDX_W-1:0] midx_r;
  logic              sq_r;
  logic [TAG_W-1:0]  sqtag_r;
  logic [TAG_W-1:0]  head_r;

  // Scan state.
  logic [SW-1:0]     scan_idx;
  logic              best_found;
  logic [SW-1:0]     best_idx;
  logic [AW-1:0]     best_age;
  logic [ADDR_W-1:0] best_addr;
  logic [TAG_W-1:0]  best_tag;
  logic [MIDX_W-1:0] best_midx;
  logic              free_found;
  logic [SW-1:0]     free_idx;
  logic              full_r;

  // Result register.
  logic              res_valid;
  logic [ADDR_W-1:0] res_addr;
  logic [TAG_W-1:0]  res_tag;
  logic [MIDX_W-1:0] res_midx;
  logic              res_full;

  // Combinational helpers.
  logic [AW-1:0]     head_m;
  logic [AW-1:0]     cur_age;
  logic              take;
  logic              ins;
  logic [AW-1:0]     limit;
  logic [SLOTS-1:0]  hit_ins;
  logic [SLOTS-1:0]  keep;
  logic [SLOTS-1:0]  drop;
  logic [SLOTS-1:0]  valid_next;
  logic [TAG_W-1:0]  tag_after [SLOTS];

  assign head_m        = tag_mod(head_r);
  assign sts.scan_last = (scan_idx == LAST_IDX);

  // The slot under the scan pointer replaces the best so far if strictly older.
  assign cur_age = age_of(slot_tag[scan_idx], head_m);
  assign take    = slot_valid[scan_idx] && (!best_found || (cur_age < best_age));

  // Commit: free the given-out slot, insert into the first free slot, squash.
  assign ins   = dv_r && free_found;
  assign limit = age_of(sqtag_r, head_m);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_ins[i]    = ins && (free_idx == SW'(i));
      tag_after[i]  = hit_ins[i] ? tag_r : slot_tag[i];
      keep[i]       = (slot_valid[i] && !(best_found && (best_idx == SW'(i)))) ||
                      hit_ins[i];
      drop[i]       = sq_r && (age_of(tag_after[i], head_m) >= limit);
      valid_next[i] = keep[i] && !drop[i];
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      scan_idx   <= '0;
      best_found <= 1'b0;
      free_found <= 1'b0;
      full_r     <= 1'b1;
    end else begin
      if (cmd.load) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
        free_found <= 1'b0;
        full_r     <= 1'b1;
      end else if (cmd.scan) begin
        scan_idx <= sts.scan_last ? '0 : scan_idx + 1'b1;
        if (take) begin
          best_found <= 1'b1;
        end
        if (!slot_valid[scan_idx]) begin
          full_r     <= 1'b0;
          free_found <= 1'b1;
        end
      end
      if (cmd.commit) begin
        slot_valid <= valid_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dv_r    <= in_data[0];
      addr_r  <= in_data[32:1] + in_data[64:33];
      tag_r   <= in_data[69:65];
      midx_r  <= in_data[73:70];
      sq_r    <= in_data[74];
      sqtag_r <= in_data[79:75];
      head_r  <= in_data[84:80];
    end
    if (cmd.scan) begin
      if (take) begin
        best_idx  <= scan_idx;
        best_age  <= cur_age;
        best_addr <= slot_address[scan_idx];
        best_tag  <= slot_tag[scan_idx];
        best_midx <= slot_qidx[scan_idx];
      end
      if (!slot_valid[scan_idx] && !free_found) begin
        free_idx <= scan_idx;
      end
    end
    if (cmd.commit) begin
      if (ins) begin
        slot_address[free_idx] <= addr_r;
        slot_tag[free_idx]     <= tag_r;
        slot_qidx[free_idx]    <= midx_r;
      end
      res_valid <= best_found;
      res_addr  <= best_found ? best_addr : '0;
      res_tag   <= best_found ? best_tag : '0;
      res_midx  <= best_found ? best_midx : '0;
      res_full  <= full_r;
    end
  end

  assign out_data = {{(aoab_pkg::OUT_TDATA_W - aoab_pkg::OUT_BITS){1'b0}},
                     res_full, res_midx, res_tag, res_addr, res_valid};

endmodule

`default_nettype wire

// ----- design/aoab_chk.sv -----
// Port-level checker for the age-ordered address buffer, bound to the top
// level. Uses the assertion macros header and aoab_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "age_ordered_address_buffer_macros.svh"

module aoab_chk (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [aoab_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [aoab_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A stalled result beat holds its value.
  `AOAB_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

  // With no entry given out, the entry fields read as zero.
  `AOAB_ASSERT_IMPLY(a_empty_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[41:1] == '0, "entry fields not zero without head_valid")

  // Padding above buffer_full stays zero.
  `AOAB_ASSERT_IMPLY(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[aoab_pkg::OUT_TDATA_W-1:aoab_pkg::OUT_BITS] == '0, "result padding not zero")

  // After a beat is taken the input closes while the slots are scanned.
  `AOAB_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_beat, !s_axis_tready && !$rose(m_axis_tvalid), "input open or result raised right after accept")

endmodule

bind age_ordered_address_buffer aoab_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the age-ordered address buffer: directed and random ticks,
// a tick-by-tick predictor of the slots, and a field-by-field check of every result beat.
// Depends on aoab_pkg and age_ordered_address_buffer.
`timescale 1ns / 1ps

module testbench;

  localparam int ADDR_W       = aoab_pkg::ADDR_W;
  localparam int TAG_W        = aoab_pkg::TAG_W;
  localparam int MIDX_W       = aoab_pkg::MIDX_W;
  localparam int IN_BITS      = aoab_pkg::IN_BITS;
  localparam int IN_TDATA_W   = aoab_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W  = aoab_pkg::OUT_TDATA_W;
  localparam int SLOT_COUNT   = aoab_pkg::DEF_SLOTS;
  localparam int ROB_SPAN     = aoab_pkg::DEF_ROB_DEPTH;
  localparam int LATENCY      = SLOT_COUNT + 2;
  localparam int RANDOM_TICKS = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;

  // One input beat, unpacked into its fields.
  typedef struct {
    logic              dispatch_valid;
    logic [ADDR_W-1:0] operand_a;
    logic [ADDR_W-1:0] operand_b;
    logic [TAG_W-1:0]  rob_tag;
    logic [MIDX_W-1:0] mem_index;
    logic              squash;
    logic [TAG_W-1:0]  squash_tag;
    logic [TAG_W-1:0]  rob_head;
  } tick_t;

  // One result beat, unpacked into its fields.
  typedef struct {
    logic              head_valid;
    logic [ADDR_W-1:0] head_address;
    logic [TAG_W-1:0]  head_rob_tag;
    logic [MIDX_W-1:0] head_mem_index;
    logic              buffer_full;
  } head_t;

  // Ready patterns of the receiving side.
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_THIRD} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  age_ordered_address_buffer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the slots.
  logic              shadow_valid [SLOT_COUNT];
  logic [ADDR_W-1:0] shadow_address [SLOT_COUNT];
  logic [TAG_W-1:0]  shadow_tag [SLOT_COUNT];
  logic [MIDX_W-1:0] shadow_index [SLOT_COUNT];

  tick_t tick_queue[$];
  head_t expected_heads[$];
  tick_t offered_tick;

  int unsigned fail_count = 0;
  int unsigned heads_checked = 0;
  int unsigned ticks_sent = 0;
  int unsigned dispatch_count = 0;
  int unsigned squash_count = 0;
  int unsigned given_out_count = 0;
  int unsigned cycle_count = 0;

  // Distance of a tag from the reorder-buffer head; smaller means older.
  function automatic int unsigned age_from(input logic [TAG_W-1:0] tag,
                                           input logic [TAG_W-1:0] head);
    return (int'(tag) % ROB_SPAN + ROB_SPAN - int'(head) % ROB_SPAN) % ROB_SPAN;
  endfunction

  // Apply one tick to the shadow slots and return the beat it must produce.
  function automatic head_t advance_buffer(input tick_t t);
    head_t       h;
    int          oldest;
    int          free_slot;
    int unsigned oldest_age;
    int unsigned limit;
    oldest = -1;
    free_slot = -1;
    oldest_age = 0;
    h.buffer_full = 1'b1;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (shadow_valid[i]) begin
        if (oldest < 0 || age_from(shadow_tag[i], t.rob_head) < oldest_age) begin
          oldest = i;
          oldest_age = age_from(shadow_tag[i], t.rob_head);
        end
      end else begin
        h.buffer_full = 1'b0;
        if (free_slot < 0) free_slot = i;
      end
    end
    // The oldest entry is reported from the state before this tick's insert.
    if (oldest >= 0) begin
      h.head_valid = 1'b1;
      h.head_address = shadow_address[oldest];
      h.head_rob_tag = shadow_tag[oldest];
      h.head_mem_index = shadow_index[oldest];
    end else begin
      h.head_valid = 1'b0;
      h.head_address = '0;
      h.head_rob_tag = '0;
      h.head_mem_index = '0;
    end
    // A dispatch with no free slot is dropped without notice.
    if (t.dispatch_valid && free_slot >= 0) begin
      shadow_valid[free_slot] = 1'b1;
      shadow_address[free_slot] = t.operand_a + t.operand_b;
      shadow_tag[free_slot] = t.rob_tag;
      shadow_index[free_slot] = t.mem_index;
    end
    if (oldest >= 0) shadow_valid[oldest] = 1'b0;
    // Squash drops everything as young as the squash tag, this tick's insert too.
    if (t.squash) begin
      limit = age_from(t.squash_tag, t.rob_head);
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (shadow_valid[i] && !(age_from(shadow_tag[i], t.rob_head) < limit)) begin
          shadow_valid[i] = 1'b0;
        end
      end
    end
    return h;
  endfunction

  function automatic tick_t make_tick(input logic dv, input logic [ADDR_W-1:0] a,
                                      input logic [ADDR_W-1:0] b, input logic [TAG_W-1:0] tag,
                                      input logic [MIDX_W-1:0] midx, input logic sq,
                                      input logic [TAG_W-1:0] sq_tag,
                                      input logic [TAG_W-1:0] head);
    tick_t t;
    t.dispatch_valid = dv;
    t.operand_a = a;
    t.operand_b = b;
    t.rob_tag = tag;
    t.mem_index = midx;
    t.squash = sq;
    t.squash_tag = sq_tag;
    t.rob_head = head;
    return t;
  endfunction

  // Operand values lean toward the extremes now and then.
  function automatic logic [ADDR_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [ADDR_W-1:0] expected,
                             input logic [ADDR_W-1:0] actual);
    if (expected !== actual) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
      fail_count++;
    end
  endtask

  // Clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [TAG_W-1:0] head;
    logic [TAG_W-1:0] tag;
    for (int i = 0; i < SLOT_COUNT; i++) shadow_valid[i] = 1'b0;

    // Directed ticks. With one entry leaving every tick the buffer never holds
    // more than one entry, so the full flag stays low at this depth.
    tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    tick_queue.push_back(make_tick(1, 0, 0, 0, 0, 0, 0, 0));
    tick_queue.push_back(make_tick(1, '1, 1, 31, 15, 0, 0, 0));
    tick_queue.push_back(make_tick(1, '1, '1, 5, 7, 0, 0, 31));
    // Squash at the inserted tag: the insert is dropped, the head still reported.
    tick_queue.push_back(make_tick(1, 32'h1234_0000, 32'h0000_5678, 6, 9, 1, 6, 31));
    tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 31));
    tick_queue.push_back(make_tick(1, 32'h0000_1000, 32'h0000_0010, 10, 3, 0, 0, 8));
    // Squash that hits both the given-out entry and an insert behind the head.
    tick_queue.push_back(make_tick(1, 32'h0000_2000, 32'h0000_0020, 3, 4, 1, 9, 8));
    tick_queue.push_back(make_tick(1, 32'hDEAD_0000, 32'h0000_BEEF, 20, 1, 1, 20, 20));
    // Squash older than nothing held: the insert survives.
    tick_queue.push_back(make_tick(1, 32'hCAFE_0000, 32'h0000_F00D, 21, 2, 1, 25, 20));
    tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 1, 0, 0));
    tick_queue.push_back(make_tick(1, 32'h8000_0000, 32'h8000_0000, 0, 15, 0, 0, 31));
    tick_queue.push_back(make_tick(1, 32'hAAAA_AAAA, 32'h5555_5555, 31, 0, 0, 31, 31));
    tick_queue.push_back(make_tick(1, 32'h1234_5678, 0, 16, 8, 1, 15, 16));
    tick_queue.push_back(make_tick(1, 0, '1, 17, 14, 1, 17, 16));
    tick_queue.push_back(make_tick(0, '1, '1, 31, 15, 1, 31, 16));
    tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 1, 5, 3));
    tick_queue.push_back(make_tick(1, 32'h0000_0001, 32'hFFFF_FFFE, 4, 5, 0, 0, 3));
    tick_queue.push_back(make_tick(1, 32'h7FFF_FFFF, 32'h0000_0001, 2, 6, 0, 0, 3));
    tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 3));

    // Random ticks: a head that mostly drifts forward, tags near it, rare squashes.
    head = TAG_W'($urandom_range(0, 31));
    for (int n = 0; n < RANDOM_TICKS; n++) begin
      if ($urandom_range(0, 19) == 0) head = TAG_W'($urandom_range(0, 31));
      else head = head + TAG_W'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) tag = TAG_W'($urandom_range(0, 31));
      else tag = head + TAG_W'($urandom_range(0, 6));
      tick_queue.push_back(make_tick(
          $urandom_range(0, 99) < 85, pick_operand(), pick_operand(), tag,
          MIDX_W'($urandom_range(0, 15)), $urandom_range(0, 99) < 12,
          ($urandom_range(0, 1) == 0) ? tag : TAG_W'($urandom_range(0, 31)), head));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (tick_queue.size() != 0 || s_axis_tvalid || expected_heads.size() != 0) begin
      @(posedge clk);
    end
    repeat (3 * LATENCY) @(posedge clk);

    $display("Sent %0d ticks (%0d dispatches, %0d squashes) under bursty input and stalls.",
             ticks_sent, dispatch_count, squash_count);
    $display("Checked %0d result beats, %0d of them giving out an entry.",
             heads_checked, given_out_count);
    if (fail_count == 0) begin
      $display("age_ordered_address_buffer regression: pass");
    end else begin
      $display("age_ordered_address_buffer regression: fail");
    end
    $finish;
  end

  // Driver: offers ticks in bursts with random gaps; predicts on each accepted beat.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_heads.push_back(advance_buffer(offered_tick));
        ticks_sent++;
        if (offered_tick.dispatch_valid) dispatch_count++;
        if (offered_tick.squash) squash_count++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          offered_tick = tick_queue.pop_front();
          s_axis_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, offered_tick.rob_head,
                           offered_tick.squash_tag, offered_tick.squash,
                           offered_tick.mem_index, offered_tick.rob_tag,
                           offered_tick.operand_b, offered_tick.operand_a,
                           offered_tick.dispatch_valid};
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches among ready patterns and holds off once for a long stretch.
  rx_mode_t    rx_mode = RX_FREE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned beats_taken = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) beats_taken++;
      if (!hold_done && beats_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          RX_FREE:  m_axis_tready <= 1'b1;
          RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
          default:  m_axis_tready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // Monitor: compares each result beat with the oldest prediction.
  always @(posedge clk) begin
    head_t expected;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_heads.size() == 0) begin
        $error("result beat 0x%0h arrived with no prediction waiting", m_axis_tdata);
        fail_count++;
      end else begin
        expected = expected_heads.pop_front();
        check_field("head_valid", ADDR_W'(expected.head_valid), ADDR_W'(m_axis_tdata[0]));
        check_field("head_address", expected.head_address, m_axis_tdata[ADDR_W:1]);
        check_field("head_rob_tag", ADDR_W'(expected.head_rob_tag),
                    ADDR_W'(m_axis_tdata[ADDR_W+TAG_W:ADDR_W+1]));
        check_field("head_mem_index", ADDR_W'(expected.head_mem_index),
                    ADDR_W'(m_axis_tdata[ADDR_W+TAG_W+MIDX_W:ADDR_W+TAG_W+1]));
        check_field("buffer_full", ADDR_W'(expected.buffer_full),
                    ADDR_W'(m_axis_tdata[ADDR_W+TAG_W+MIDX_W+1]));
        if (expected.head_valid) given_out_count++;
        heads_checked++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d ticks unsent and %0d results missing.",
               cycle_count, tick_queue.size(), expected_heads.size());
      $display("age_ordered_address_buffer regression: fail");
      $finish;
    end
  end

endmodule
